>>> hdl/fba_pkg.sv
package fba_pkg;

    // Fixed field widths of the request, the result and the size register.
    localparam int IDX_W  = 10;
    localparam int SIZE_W = 11;
    localparam int OP_W   = 2;

    // Managed size after reset.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

    // Request opcodes; the unused code behaves as a test.
    localparam logic [OP_W-1:0] OP_TEST  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [IDX_W-1:0] bit_index;
    } t_fba_req;

    typedef struct packed {
        logic              out_of_range;
        logic              previous_value;
        logic [SIZE_W-1:0] used_count;
        logic [SIZE_W-1:0] free_count;
        logic              free_found;
        logic [IDX_W-1:0]  first_free;
    } t_fba_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_READ,
        ST_MODIFY,
        ST_SCAN,
        ST_FINISH
    } t_fba_state;

endpackage

>>> hdl/fba_if.sv
// Request channel.
interface fba_req_if;
    import fba_pkg::*;
    logic     valid;
    logic     ready;
    t_fba_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Result channel.
interface fba_rsp_if;
    import fba_pkg::*;
    logic     valid;
    logic     ready;
    t_fba_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Size register write channel.
interface fba_cfg_if;
    import fba_pkg::*;
    logic              valid;
    logic              ready;
    logic [SIZE_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/fba_ram.sv
module fba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/fba_scan.sv
module fba_scan #(
    parameter int WORD_BITS = 8,
    parameter int BASE_W = 12,
    parameter int LIM_W = 11
) (
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [BASE_W-1:0]    i_base,
    input  logic [LIM_W-1:0]     i_lim,
    output logic                 o_hit,
    output logic [BASE_W-1:0]    o_pos
);

    // Lowest clear bit of one word whose absolute index lies below the limit.
    always_comb begin
        logic [BASE_W-1:0] pos_j;
        o_hit = 1'b0;
        o_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            pos_j = i_base + BASE_W'(j);
            if (!i_word[j] && (pos_j < BASE_W'(i_lim))) begin
                o_hit = 1'b1;
                o_pos = pos_j;
            end
        end
    end

endmodule

>>> hdl/free_bitmap_allocator.sv
// Allocation bitmap with find-first-zero.
//
// Requests arrive on i_req (opcode and bit index) and each produces exactly
// one transaction on o_rsp. The managed size is written on i_cfg, which is
// always ready; it should only be written while no request is in flight.
// The map lives in one word-wide synchronous RAM. A request takes a split of
// the index into word and bit, one read, one write-back of the updated word,
// then a scan that reads the map one word per cycle from word zero until a
// clear bit below the size is found. The next request is taken in the cycle
// after the result is registered. Only one request is in flight at a time.
// The finished result sits in an output register; a new request is taken
// while it waits, and the block stalls at the end of that next request's
// scan until the receiver has taken the earlier result.
// After reset the RAM is cleared one word per cycle, during which i_req is
// not ready.
module free_bitmap_allocator #(
    parameter int CAPACITY_BITS = 1024,
    parameter int WORD_BITS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fba_req_if.sink   i_req,
    fba_rsp_if.source o_rsp,
    fba_cfg_if.sink   i_cfg
);

    import fba_pkg::*;

    localparam int DEPTH   = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BIT_W   = $clog2(WORD_BITS);
    localparam int BASE_W  = $clog2(2048 + WORD_BITS);
    // Exact division of an index by the word size through a reciprocal.
    localparam int DIV_K   = IDX_W + BIT_W;
    localparam int DIV_M   = (2 ** DIV_K + WORD_BITS - 1) / WORD_BITS;
    localparam int PROD_W  = IDX_W + DIV_K + 1;

    t_fba_state          r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [SIZE_W-1:0]   r_size;
    logic [SIZE_W-1:0]   r_ones, n_ones;
    logic                r_pend, n_pend;
    logic                r_out_valid, n_out_valid;
    t_fba_rsp            r_out, n_out;
    t_fba_req            r_req, n_req;
    logic                r_oor, n_oor;
    logic [ADDR_W-1:0]   r_word, n_word;
    logic [BIT_W-1:0]    r_bit, n_bit;
    logic                r_prev, n_prev;
    logic [ADDR_W-1:0]   r_scan_addr, n_scan_addr;
    logic [BASE_W-1:0]   r_scan_base, n_scan_base;
    logic [BASE_W-1:0]   r_chk_base, n_chk_base;
    logic                r_found, n_found;
    logic [IDX_W-1:0]    r_ff, n_ff;

    logic [SIZE_W-1:0]   lim;
    logic [SIZE_W-1:0]   free_cnt;
    logic [PROD_W-1:0]   split_prod;
    logic [IDX_W-1:0]    split_rem;
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata, ram_rdata;
    logic                scan_issue;
    logic                scan_hit;
    logic [BASE_W-1:0]   scan_pos;
    logic                cur_bit;

    // Size in use, capped at the capacity.
    assign lim = (32'(r_size) > CAPACITY_BITS) ? SIZE_W'(CAPACITY_BITS) : r_size;
    assign free_cnt = (lim > r_ones) ? (lim - r_ones) : '0;

    // Word and bit position of the requested index.
    assign split_prod = PROD_W'(r_req.bit_index) * PROD_W'(DIV_M);
    assign split_rem  = r_req.bit_index - IDX_W'(IDX_W'(r_word) * IDX_W'(WORD_BITS));

    assign cur_bit    = ram_rdata[r_bit];
    assign scan_issue = (r_scan_base < BASE_W'(lim));

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    fba_scan #(
        .WORD_BITS (WORD_BITS),
        .BASE_W    (BASE_W),
        .LIM_W     (SIZE_W)
    ) u_scan (
        .i_word (ram_rdata),
        .i_base (r_chk_base),
        .i_lim  (lim),
        .o_hit  (scan_hit),
        .o_pos  (scan_pos)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // Sequencer: next state, RAM accesses and working registers.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_ones      = r_ones;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_req       = r_req;
        n_oor       = r_oor;
        n_word      = r_word;
        n_bit       = r_bit;
        n_prev      = r_prev;
        n_scan_addr = r_scan_addr;
        n_scan_base = r_scan_base;
        n_chk_base  = r_chk_base;
        n_found     = r_found;
        n_ff        = r_ff;
        ram_we      = 1'b0;
        ram_waddr   = r_word;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = r_word;

        if (o_rsp.valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_req   = i_req.data;
                    n_oor   = ({1'b0, i_req.data.bit_index} >= lim);
                    n_state = ST_SPLIT;
                end
            end
            ST_SPLIT: begin
                n_word  = ADDR_W'(split_prod >> DIV_K);
                n_state = ST_READ;
            end
            ST_READ: begin
                n_bit   = BIT_W'(split_rem);
                ram_re  = 1'b1;
                n_state = ST_MODIFY;
            end
            ST_MODIFY: begin
                n_prev = r_oor ? 1'b0 : cur_bit;
                if (!r_oor) begin
                    if ((r_req.opcode == OP_SET) && !cur_bit) begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata | (WORD_BITS'(1) << r_bit);
                        n_ones    = r_ones + 1'b1;
                    end else if ((r_req.opcode == OP_CLEAR) && cur_bit) begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~(WORD_BITS'(1) << r_bit);
                        n_ones    = r_ones - 1'b1;
                    end
                end
                n_scan_addr = '0;
                n_scan_base = '0;
                n_found     = 1'b0;
                n_ff        = '0;
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                // Read the next word while checking the one read last cycle.
                if (scan_issue) begin
                    ram_re      = 1'b1;
                    ram_raddr   = r_scan_addr;
                    n_scan_addr = r_scan_addr + 1'b1;
                    n_scan_base = r_scan_base + BASE_W'(WORD_BITS);
                    n_chk_base  = r_scan_base;
                    n_pend      = 1'b1;
                end
                if (r_pend && scan_hit) begin
                    n_found = 1'b1;
                    n_ff    = IDX_W'(scan_pos);
                    n_pend  = 1'b0;
                    n_state = ST_FINISH;
                end else if (!r_pend && !scan_issue) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid          = 1'b1;
                    n_out.out_of_range   = r_oor;
                    n_out.previous_value = r_prev;
                    n_out.used_count     = r_ones;
                    n_out.free_count     = free_cnt;
                    n_out.free_found     = r_found;
                    n_out.first_free     = r_ff;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_size      <= SIZE_RESET;
            r_ones      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_ones      <= n_ones;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_size <= i_cfg.data;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_out       <= n_out;
        r_req       <= n_req;
        r_oor       <= n_oor;
        r_word      <= n_word;
        r_bit       <= n_bit;
        r_prev      <= n_prev;
        r_scan_addr <= n_scan_addr;
        r_scan_base <= n_scan_base;
        r_chk_base  <= n_chk_base;
        r_found     <= n_found;
        r_ff        <= n_ff;
    end

endmodule

>>> hdl/fba_checker.sv
module fba_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input fba_pkg::t_fba_rsp i_rsp_data
);

    import fba_pkg::*;

    // A result waiting for the receiver stays put.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("result changed or vanished while stalled");

    // One request at a time: ready drops right after a transaction.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in flight");

    // An out-of-range request reports a clear previous value.
    a_oor_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.out_of_range |-> !i_rsp_data.previous_value)
        else $error("out-of-range result with previous value set");

    // A free count above zero means a clear bit must have been found.
    a_free_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_data.free_count != '0) |-> i_rsp_data.free_found)
        else $error("free bits counted but none found");

    // Without a find, the reported position is zero.
    a_ff_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_data.free_found |-> (i_rsp_data.first_free == '0))
        else $error("first free position given without a find");

endmodule

bind free_bitmap_allocator fba_checker u_fba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

>>> test/fba_checker.sv
// Watches the request, result and size channels of the allocator, keeps its
// own copy of the bitmap and predicts every result.
module fba_scoreboard
    import fba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    fba_req_if   i_req,
    fba_rsp_if   i_rsp,
    fba_cfg_if   i_cfg,
    output int   o_error_count,
    output int   o_outstanding
);

    localparam int MAP_BITS = 1024;

    // Shadow copy of the map, the set-bit count and the size register.
    bit [MAP_BITS-1:0] shadow_map;
    int                shadow_ones;
    logic [SIZE_W-1:0] shadow_size;

    // Results predicted but not yet seen on the result channel.
    t_fba_rsp pending_results[$];

    // Applies one request to the shadow map and returns the result it must give.
    function automatic t_fba_rsp apply_request(t_fba_req req);
        t_fba_rsp res;
        int       limit;
        bit       old_bit;
        res = '0;
        limit = (shadow_size > MAP_BITS) ? MAP_BITS : int'(shadow_size);
        res.out_of_range = (int'(req.bit_index) >= limit);
        if (!res.out_of_range) begin
            old_bit = shadow_map[req.bit_index];
            res.previous_value = old_bit;
            if (req.opcode == OP_SET && !old_bit) begin
                shadow_map[req.bit_index] = 1'b1;
                shadow_ones++;
            end else if (req.opcode == OP_CLEAR && old_bit) begin
                shadow_map[req.bit_index] = 1'b0;
                shadow_ones--;
            end
        end
        // The lowest clear bit below the size in use.
        for (int i = 0; i < limit && !res.free_found; i++) begin
            if (!shadow_map[i]) begin
                res.free_found = 1'b1;
                res.first_free = IDX_W'(i);
            end
        end
        res.used_count = SIZE_W'(shadow_ones);
        res.free_count = (limit > shadow_ones) ? SIZE_W'(limit - shadow_ones) : '0;
        return res;
    endfunction

    // Reports one field that differs from its prediction.
    task automatic check_field(input string field, input int expected_v, input int actual_v);
        if (expected_v != actual_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, field, expected_v, actual_v);
            o_error_count++;
        end
    endtask

    // Every transaction is taken at the rising edge at which valid and ready are high.
    always @(posedge i_clk) begin
        t_fba_rsp want;
        t_fba_rsp got;
        if (!i_rst_n) begin
            shadow_map = '0;
            shadow_ones = 0;
            shadow_size = SIZE_RESET;
            pending_results.delete();
            o_error_count = 0;
        end else begin
            // Result transaction: compare with the oldest prediction.
            if (i_rsp.valid && i_rsp.ready) begin
                got = i_rsp.data;
                if (pending_results.size() == 0) begin
                    $display("%0t: result with no request outstanding: expected none, actual %h",
                             $time, got);
                    o_error_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("out_of_range", want.out_of_range, got.out_of_range);
                    check_field("previous_value", want.previous_value, got.previous_value);
                    check_field("used_count", want.used_count, got.used_count);
                    check_field("free_count", want.free_count, got.free_count);
                    check_field("free_found", want.free_found, got.free_found);
                    check_field("first_free", want.first_free, got.first_free);
                end
            end
            // Size register write.
            if (i_cfg.valid && i_cfg.ready) begin
                shadow_size = i_cfg.data;
            end
            // Request transaction: predict its result.
            if (i_req.valid && i_req.ready) begin
                pending_results.push_back(apply_request(i_req.data));
            end
        end
        o_outstanding = pending_results.size();
    end

endmodule

>>> test/tb_free_bitmap_allocator.sv
// Drives requests and size writes into the allocator and gives the verdict.
module tb_free_bitmap_allocator;

    import fba_pkg::*;

    // The unused opcode, which the block handles as a test.
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int MAP_BITS = 1024;

    logic i_clk;
    logic i_rst_n;

    fba_req_if req_ch ();
    fba_rsp_if rsp_ch ();
    fba_cfg_if cfg_ch ();

    int error_count;
    int outstanding;
    int send_idle_pct;
    int recv_stall_pct;
    int size_now;

    free_bitmap_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    fba_scoreboard checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_rsp         (rsp_ch),
        .i_cfg         (cfg_ch),
        .o_error_count (error_count),
        .o_outstanding (outstanding)
    );

    // Clock with a period of 10.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver side: ready stalls at the rate of the current phase.
    always @(negedge i_clk) begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard limit on the run.
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Sends one request; called and returning at a falling edge.
    task automatic send_request(input logic [OP_W-1:0] op, input int idx);
        t_fba_req req;
        req.opcode = op;
        req.bit_index = IDX_W'(idx);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= req;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Holds off new requests until every predicted result has come back.
    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    // Writes the size register once the block is idle.
    task automatic write_size(input int size);
        wait_all_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= SIZE_W'(size);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        size_now = size;
    endtask

    // One random request: mostly sets and clears near the bottom of the map,
    // so that the first free bit keeps moving, with some noise on top.
    task automatic send_random_request();
        int               limit;
        int               idx;
        int               pick;
        logic [OP_W-1:0]  op;
        limit = (size_now > MAP_BITS) ? MAP_BITS : size_now;
        pick = $urandom_range(99);
        if (limit == 0 || pick >= 85) begin
            idx = $urandom_range(MAP_BITS - 1);
        end else if (pick < 55) begin
            idx = $urandom_range(((limit < 48) ? limit : 48) - 1);
        end else begin
            idx = $urandom_range(limit - 1);
        end
        pick = $urandom_range(99);
        if (pick < 50) begin
            op = OP_SET;
        end else if (pick < 78) begin
            op = OP_CLEAR;
        end else if (pick < 95) begin
            op = OP_TEST;
        end else begin
            op = OP_SPARE;
        end
        send_request(op, idx);
    endtask

    // One phase of random traffic at a given size and idling rate.
    task automatic run_phase(input int idle_pct, input int stall_pct, input int size,
                             input int count);
        write_size(size);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            // Midway through, the sender pauses until the block has drained.
            if (n == count / 2) wait_all_results();
            send_random_request();
        end
    endtask

    initial begin
        req_ch.valid <= 1'b0;
        req_ch.data <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data <= '0;
        i_rst_n <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        size_now = SIZE_RESET;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset size: repeated set and clear, top bit,
        // spare opcode.
        send_request(OP_TEST, 0);
        send_request(OP_SET, 0);
        send_request(OP_SET, 0);
        send_request(OP_SET, 1);
        send_request(OP_CLEAR, 0);
        send_request(OP_CLEAR, 0);
        send_request(OP_SET, MAP_BITS - 1);
        send_request(OP_SPARE, MAP_BITS - 1);
        send_request(OP_CLEAR, MAP_BITS - 1);

        // Size zero: everything is out of range and nothing is free.
        write_size(0);
        send_request(OP_TEST, 5);
        send_request(OP_SET, 0);

        // A size above the capacity acts as the full map.
        write_size((1 << SIZE_W) - 1);
        send_request(OP_SET, MAP_BITS - 1);
        send_request(OP_CLEAR, MAP_BITS - 1);

        // Fill a small map completely, then shrink it below the set bits.
        write_size(8);
        for (int i = 2; i < 8; i++) send_request(OP_SET, i);
        send_request(OP_SET, 0);
        send_request(OP_SET, 8);
        write_size(3);
        send_request(OP_TEST, 2);
        send_request(OP_CLEAR, 7);

        // Random part, one phase per idling pattern.
        run_phase(0, 0, MAP_BITS, 140);
        run_phase(48, 0, $urandom_range(1, 40), 130);
        run_phase(0, 48, 1, 20);
        run_phase(0, 48, MAP_BITS, 120);
        run_phase(18, 18, $urandom_range(200, MAP_BITS - 1), 120);

        wait_all_results();
        repeat (150) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
